[src/accel_step_detector_core_assert.svh]
// Assertion helpers for the step detector core.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ACCEL_STEP_DETECTOR_CORE_ASSERT_SVH
`define ACCEL_STEP_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define ASD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[src/asd_pkg.sv]
`default_nettype none

package asd_pkg;

  // Sample and window geometry (window depths are powers of two)
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned LONG_N    = 16;
  localparam int unsigned SHORT_N   = 4;
  localparam int unsigned LONG_LOG  = $clog2(LONG_N);
  localparam int unsigned SHORT_LOG = $clog2(SHORT_N);

  // Running sums and rounding numerators
  localparam int unsigned LSUM_W = SAMPLE_W + LONG_LOG;
  localparam int unsigned SSUM_W = SAMPLE_W + SHORT_LOG;
  localparam int unsigned NUM_W  = LSUM_W + 2;

  // Averages, magnitudes, squares
  localparam int unsigned AVG_W  = SAMPLE_W + 1;
  localparam int unsigned MAG_W  = AVG_W;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned ESUM_W = SQ_W + 2;

  // Energy scaling and result widths
  localparam int unsigned ENERGY_SHIFT = 6;
  localparam int unsigned EFULL_W      = ESUM_W - ENERGY_SHIFT;
  localparam int unsigned ENERGY_W     = 28;
  localparam int unsigned STEP_W       = 32;

  // Configuration
  localparam int unsigned REG_W     = 16;
  localparam int unsigned THR_W     = REG_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [REG_W-1:0] SENS_RESET = REG_W'(120);
  localparam logic [REG_W-1:0] HYST_RESET = REG_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS = 2'd0,
    REG_HYST = 2'd1
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [LSUM_W-1:0]   lsum_t;
  typedef logic signed [SSUM_W-1:0]   ssum_t;
  typedef logic signed [AVG_W-1:0]    avg_t;
  typedef logic        [MAG_W-1:0]    mag_t;
  typedef logic        [SQ_W-1:0]     sq_t;

  // Pipeline load enables, driven by the top-level valid/ready chain
  typedef struct packed {
    logic push;       // new word enters the history
    logic load_mag;   // average difference magnitude register
    logic load_sq;    // square register
    logic load_out;   // result register and hysteresis state
  } pipe_ctl_t;

  // trunc_toward_zero((2*sum + n) / (2n)) with n = 2**log_n
  function automatic avg_t round_avg(input lsum_t sum, input int unsigned log_n);
    logic signed [NUM_W-1:0] num;
    num = (NUM_W'(sum) <<< 1) + signed'(NUM_W'(1) << log_n);
    // bias negative numerators so the arithmetic shift truncates toward zero
    if (num[NUM_W-1]) begin
      num = num + signed'((NUM_W'(1) << (log_n + 1)) - NUM_W'(1));
    end
    return AVG_W'(num >>> (log_n + 1));
  endfunction

endpackage

`default_nettype wire

[src/asd_axis.sv]
`default_nettype none

// One axis: sample history, running sums, short-minus-long magnitude, square.
module asd_axis (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asd_pkg::pipe_ctl_t ctl_i,
  input  wire asd_pkg::sample_t  sample_i,
  output asd_pkg::sq_t           sq_o
);

  asd_pkg::sample_t hist_q [asd_pkg::LONG_N];
  asd_pkg::lsum_t   sum_l_q, sum_l_d;
  asd_pkg::ssum_t   sum_s_q, sum_s_d;
  asd_pkg::avg_t    avg_s, avg_l;
  asd_pkg::avg_t    diff;
  asd_pkg::mag_t    mag, mag_q;
  asd_pkg::sq_t     sq_q;

  // running sums: add the new word, drop the one leaving each window
  assign sum_l_d = sum_l_q + asd_pkg::LSUM_W'(sample_i)
                 - asd_pkg::LSUM_W'(hist_q[asd_pkg::LONG_N-1]);
  assign sum_s_d = sum_s_q + asd_pkg::SSUM_W'(sample_i)
                 - asd_pkg::SSUM_W'(hist_q[asd_pkg::SHORT_N-1]);

  // history shift line, newest at tap 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < asd_pkg::LONG_N; i++) begin
        hist_q[i] <= '0;
      end
      sum_l_q <= '0;
      sum_s_q <= '0;
    end else if (ctl_i.push) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < asd_pkg::LONG_N; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      sum_l_q <= sum_l_d;
      sum_s_q <= sum_s_d;
    end
  end

  // rounded averages and their difference magnitude
  always_comb begin
    avg_s = asd_pkg::round_avg(asd_pkg::LSUM_W'(sum_s_q), asd_pkg::SHORT_LOG);
    avg_l = asd_pkg::round_avg(sum_l_q, asd_pkg::LONG_LOG);
    diff  = avg_s - avg_l;
    mag   = diff[asd_pkg::AVG_W-1] ? asd_pkg::mag_t'(-diff) : asd_pkg::mag_t'(diff);
  end

  // magnitude and square registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_mag) begin
      mag_q <= mag;
    end
    if (ctl_i.load_sq) begin
      sq_q <= asd_pkg::sq_t'(mag_q) * asd_pkg::sq_t'(mag_q);
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

[src/asd_hyst.sv]
`default_nettype none

// Energy, hysteresis flag, step counter, configuration registers, result word.
module asd_hyst (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire asd_pkg::pipe_ctl_t             ctl_i,
  input  wire asd_pkg::sq_t                   sq_x_i,
  input  wire asd_pkg::sq_t                   sq_y_i,
  input  wire asd_pkg::sq_t                   sq_z_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [asd_pkg::REG_W-1:0]      cfg_data_i,
  output logic [asd_pkg::ENERGY_W-1:0]        energy_o,
  output logic                                moving_o,
  output logic                                step_o,
  output logic [asd_pkg::STEP_W-1:0]          total_o
);

  logic [asd_pkg::REG_W-1:0]    sens_q, hyst_q;
  logic [asd_pkg::REG_W-1:0]    half;
  logic [asd_pkg::THR_W-1:0]    upper, lower;
  logic [asd_pkg::ESUM_W-1:0]   esum;
  logic [asd_pkg::EFULL_W-1:0]  energy;
  logic                         step, moving_d;
  logic                         moving_q, step_q;
  logic [asd_pkg::STEP_W-1:0]   total_q, total_d;
  logic [asd_pkg::ENERGY_W-1:0] energy_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= asd_pkg::SENS_RESET;
      hyst_q <= asd_pkg::HYST_RESET;
    end else if (cfg_we_i) begin
      unique case (asd_pkg::cfg_reg_e'(cfg_index_i))
        asd_pkg::REG_SENS: sens_q <= cfg_data_i;
        asd_pkg::REG_HYST: hyst_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // thresholds; lower one saturates at zero
  always_comb begin
    half  = hyst_q >> 1;
    upper = asd_pkg::THR_W'(sens_q) + asd_pkg::THR_W'(half);
    lower = (sens_q > half) ? asd_pkg::THR_W'(sens_q - half) : '0;
  end

  // energy = floor(sum of squares / 64), then hysteresis decision
  always_comb begin
    esum = asd_pkg::ESUM_W'(sq_x_i) + asd_pkg::ESUM_W'(sq_y_i)
         + asd_pkg::ESUM_W'(sq_z_i);
    energy   = esum[asd_pkg::ESUM_W-1:asd_pkg::ENERGY_SHIFT];
    step     = moving_q && (energy < asd_pkg::EFULL_W'(lower));
    moving_d = moving_q;
    total_d  = total_q;
    if (step) begin
      moving_d = 1'b0;
      total_d  = total_q + asd_pkg::STEP_W'(1);
    end else if (!moving_q && (energy >= asd_pkg::EFULL_W'(upper))) begin
      moving_d = 1'b1;
    end
  end

  // flag and counter are both state and result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q <= 1'b0;
      total_q  <= '0;
    end else if (ctl_i.load_out) begin
      moving_q <= moving_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      energy_q <= energy[asd_pkg::ENERGY_W-1:0];
      step_q   <= step;
    end
  end

  assign energy_o = energy_q;
  assign moving_o = moving_q;
  assign step_o   = step_q;
  assign total_o  = total_q;

endmodule

`default_nettype wire

[src/accel_step_detector_core.sv]
`default_nettype none

// Step detector core. Takes one signed 16-bit X/Y/Z accelerometer word per
// cycle while not stalled and returns one result word per input word, in
// order: motion energy (floor of the summed squared short-minus-long window
// average differences, divided by 64), the moving flag, a step-completed
// pulse and the running step count (wraps at 2^32). The accept edge loads
// the history shift with running sums; the rounded averages and difference
// magnitude, one squarer per axis, and the energy sum with hysteresis update
// into the result register follow as registered stages, in that order.
// Throughput is one word per cycle; each stage holds its word only while the
// stage after it is full and stalled. Sensitivity (index 0, reset 120) and
// hysteresis (index 1, reset 30) are written through the configuration port,
// which is always ready; write them only while the pipeline is empty. Writes
// to other indexes are dropped.
`include "accel_step_detector_core_assert.svh"

module accel_step_detector_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [15:0]             accel_x_i,
  input  wire logic signed [15:0]             accel_y_i,
  input  wire logic signed [15:0]             accel_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [asd_pkg::ENERGY_W-1:0]        motion_energy_o,
  output logic                                moving_o,
  output logic                                step_seen_o,
  output logic [asd_pkg::STEP_W-1:0]          total_steps_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [asd_pkg::REG_W-1:0]      cfg_data_i
);

  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  asd_pkg::pipe_ctl_t ctl;
  asd_pkg::sq_t sq_x, sq_y, sq_z;

  // ready chain: a stage takes a word when empty or when it drains
  always_comb begin
    rdy_d = !vd_q || out_ready_i;
    rdy_c = !vc_q || rdy_d;
    rdy_b = !vb_q || rdy_c;
    rdy_a = !va_q || rdy_b;
    ctl.push     = in_valid_i && rdy_a;
    ctl.load_mag = va_q && rdy_b;
    ctl.load_sq  = vb_q && rdy_c;
    ctl.load_out = vc_q && rdy_d;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  asd_axis u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (accel_x_i),
    .sq_o     (sq_x)
  );

  asd_axis u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (accel_y_i),
    .sq_o     (sq_y)
  );

  asd_axis u_axis_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (accel_z_i),
    .sq_o     (sq_z)
  );

  asd_hyst u_hyst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sq_x_i      (sq_x),
    .sq_y_i      (sq_y),
    .sq_z_i      (sq_z),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .energy_o    (motion_energy_o),
    .moving_o    (moving_o),
    .step_o      (step_seen_o),
    .total_o     (total_steps_o)
  );

  assign in_ready_o  = rdy_a;
  assign out_valid_o = vd_q;
  assign cfg_ready_o = 1'b1;

  // a step always ends the moving state
  `ASD_ASSERT_NOW(a_step_clears_moving, out_valid_o && step_seen_o, !moving_o,
    "step reported while still moving")
  // input stalls only when every stage is full and the output is blocked
  `ASD_ASSERT_NOW(a_stall_only_when_full, !in_ready_o,
    va_q && vb_q && vc_q && vd_q && !out_ready_i,
    "input stalled with a free pipeline stage")
  // an accepted word occupies the first stage next cycle
  `ASD_ASSERT_NEXT(a_push_fills_stage, in_valid_i && in_ready_o, va_q,
    "accepted word lost at pipeline entry")

endmodule

`default_nettype wire
